FILE: sv/sts_pkg.sv
// Shared constants for the script token scanner: token kinds, error codes,
// default widths and the keyword table. No dependencies.
package sts_pkg;

    // Default widths of the position, length and line counters.
    localparam int STS_POSITION_WIDTH = 32;
    localparam int STS_LENGTH_WIDTH   = 16;
    localparam int STS_LINE_WIDTH     = 16;

    // Token kinds, in the usual clox order.
    localparam logic [5:0] K_LPAREN    = 6'd0;
    localparam logic [5:0] K_RPAREN    = 6'd1;
    localparam logic [5:0] K_LBRACE    = 6'd2;
    localparam logic [5:0] K_RBRACE    = 6'd3;
    localparam logic [5:0] K_COMMA     = 6'd4;
    localparam logic [5:0] K_DOT       = 6'd5;
    localparam logic [5:0] K_MINUS     = 6'd6;
    localparam logic [5:0] K_PLUS      = 6'd7;
    localparam logic [5:0] K_SEMICOLON = 6'd8;
    localparam logic [5:0] K_SLASH     = 6'd9;
    localparam logic [5:0] K_STAR      = 6'd10;
    localparam logic [5:0] K_BANG      = 6'd11;
    localparam logic [5:0] K_EQUAL     = 6'd13;
    localparam logic [5:0] K_GREATER   = 6'd15;
    localparam logic [5:0] K_LESS      = 6'd17;
    localparam logic [5:0] K_IDENT     = 6'd19;
    localparam logic [5:0] K_STRING    = 6'd20;
    localparam logic [5:0] K_NUMBER    = 6'd21;
    localparam logic [5:0] K_ERROR     = 6'd38;
    localparam logic [5:0] K_EOF       = 6'd39;

    // Error codes.
    localparam logic [1:0] E_NONE         = 2'd0;
    localparam logic [1:0] E_UNEXPECTED   = 2'd1;
    localparam logic [1:0] E_UNTERMINATED = 2'd2;

    localparam int KW_COUNT = 16;

    // Keywords with the first character in the lowest byte, hence reversed literals.
    localparam logic [47:0] KW_WORD [KW_COUNT] = '{
        48'("dna"), 48'("ssalc"), 48'("esle"), 48'("eslaf"),
        48'("rof"), 48'("nuf"), 48'("fi"), 48'("lin"),
        48'("ro"), 48'("tnirp"), 48'("nruter"), 48'("repus"),
        48'("siht"), 48'("eurt"), 48'("rav"), 48'("elihw")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
        3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
    };
    localparam logic [5:0] KW_KIND [KW_COUNT] = '{
        6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37
    };

endpackage

FILE: sv/sts_keyword.sv
// Keyword matcher: maps the captured identifier prefix and its length to a kind.
// Depends on sts_pkg for the keyword table.
module sts_keyword
    import sts_pkg::*;
(
    input  logic [47:0] i_window,
    input  logic [2:0]  i_length,
    output logic [5:0]  o_kind
);

    // Unused upper bytes of the window are zero, so a whole-word compare suffices.
    always_comb begin
        o_kind = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (i_length == KW_LEN[i] && i_window == KW_WORD[i]) begin
                o_kind = KW_KIND[i];
            end
        end
    end

endmodule

FILE: sv/script_token_scanner.sv
// A token caused by a byte appears on the master side in the cycle after the beat.
// Throughput: one byte per cycle while each byte causes at most one token and the master
// side is ready; a byte that causes two or three tokens holds the slave side while the
// three-entry result buffer drains one token per cycle while the master side is ready.
// Reset: synchronous, active low; idle mode, position zero, line one, buffer empty.
module script_token_scanner
    import sts_pkg::*;
#(
    parameter int POSITION_WIDTH = STS_POSITION_WIDTH,
    parameter int LENGTH_WIDTH   = STS_LENGTH_WIDTH,
    parameter int LINE_WIDTH     = STS_LINE_WIDTH,
    parameter int DATA_WIDTH     = ((8 + POSITION_WIDTH + LENGTH_WIDTH + LINE_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // char_code
    input  logic                  i_s_axis_tuser,   // end_of_source
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // token_kind, error_kind, start_offset, token_length, line_number, zero fill
    output logic [DATA_WIDTH-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tlast    // last_of_run
);

    localparam int PW = POSITION_WIDTH;
    localparam int LW = LENGTH_WIDTH;
    localparam int NW = LINE_WIDTH;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_NUMDOT, M_FRACTION,
        M_STRING, M_OPER, M_SLASH, M_COMMENT, M_DONE
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [7:0]       r_op, n_op;
    logic [PW-1:0]    r_pos, n_pos;
    logic [PW-1:0]    r_begin, n_begin;
    logic [LW-1:0]    r_span, n_span;
    logic [NW-1:0]    r_line, n_line;
    logic [47:0]      r_win, n_win;

    logic [DATA_WIDTH-1:0] r_data [3];
    logic [2:0]            r_last;
    logic [1:0]            r_cnt, r_rd;

    logic [5:0]    e_kind  [3];
    logic [1:0]    e_err   [3];
    logic [PW-1:0] e_start [3];
    logic [LW-1:0] e_len   [3];
    logic [1:0]    e_cnt;

    logic [7:0]    c;
    logic          eos, accept, absorbed, flush_now;
    logic [2:0]    kw_len;
    logic [5:0]    kw_kind;
    logic [1:0]    remaining;

    function automatic logic letter_char(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
    endfunction

    function automatic logic digit_char(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] a, input logic [1:0] k);
        logic [LW:0] s;
        s = {1'b0, a} + (LW+1)'(k);
        return s[LW] ? '1 : s[LW-1:0];
    endfunction

    function automatic logic [5:0] oper_kind(input logic [7:0] op, input logic two);
        logic [5:0] base;
        priority if (op == "!") base = K_BANG;
        else if (op == "=")     base = K_EQUAL;
        else if (op == ">")     base = K_GREATER;
        else                    base = K_LESS;
        return base + 6'(two);
    endfunction

    assign c  = i_s_axis_tdata;
    assign eos = i_s_axis_tuser;

    // Keyword lookup on the held identifier; spans beyond six never match.
    assign kw_len = (r_span > LW'(7)) ? 3'd7 : r_span[2:0];

    sts_keyword u_keyword (
        .i_window (r_win),
        .i_length (kw_len),
        .o_kind   (kw_kind)
    );

    // Buffer control: take a beat when the buffer is empty or its last token leaves now.
    assign remaining       = r_cnt - r_rd;
    assign o_s_axis_tready = (remaining == 2'd0) || (remaining == 2'd1 && i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (remaining != 2'd0);
    assign o_m_axis_tdata  = r_data[r_rd];
    assign o_m_axis_tlast  = r_last[r_rd];

    // Next state and the tokens caused by the current beat.
    always_comb begin
        n_mode  = r_mode;
        n_op    = r_op;
        n_pos   = r_pos;
        n_begin = r_begin;
        n_span  = r_span;
        n_line  = r_line;
        n_win   = r_win;
        for (int i = 0; i < 3; i++) begin
            e_kind[i]  = K_EOF;
            e_err[i]   = E_NONE;
            e_start[i] = '0;
            e_len[i]   = '0;
        end
        e_cnt     = 2'd0;
        absorbed  = 1'b0;
        flush_now = 1'b0;

        if (r_mode == M_DONE) begin
            if (eos) begin
                e_start[e_cnt] = r_pos;
                e_cnt = e_cnt + 2'd1;
            end
        end else if (eos) begin
            flush_now = 1'b1;
        end else begin
            // Try to extend the pending token with this byte.
            unique case (r_mode)
                M_IDENT: begin
                    if (letter_char(c) || digit_char(c)) begin
                        unique case (r_span)
                            LW'(0):  n_win[7:0]   = r_win[7:0]   | c;
                            LW'(1):  n_win[15:8]  = r_win[15:8]  | c;
                            LW'(2):  n_win[23:16] = r_win[23:16] | c;
                            LW'(3):  n_win[31:24] = r_win[31:24] | c;
                            LW'(4):  n_win[39:32] = r_win[39:32] | c;
                            LW'(5):  n_win[47:40] = r_win[47:40] | c;
                            default: n_win = r_win;
                        endcase
                        n_span   = sat_add(r_span, 2'd1);
                        absorbed = 1'b1;
                    end else begin
                        flush_now = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (digit_char(c)) begin
                        n_span   = sat_add(r_span, 2'd1);
                        absorbed = 1'b1;
                    end else if (c == ".") begin
                        n_mode   = M_NUMDOT;
                        absorbed = 1'b1;
                    end else begin
                        flush_now = 1'b1;
                    end
                end
                M_NUMDOT: begin
                    if (digit_char(c)) begin
                        n_span   = sat_add(r_span, 2'd2);
                        n_mode   = M_FRACTION;
                        absorbed = 1'b1;
                    end else begin
                        flush_now = 1'b1;
                    end
                end
                M_FRACTION: begin
                    if (digit_char(c)) begin
                        n_span   = sat_add(r_span, 2'd1);
                        absorbed = 1'b1;
                    end else begin
                        flush_now = 1'b1;
                    end
                end
                M_STRING: begin
                    n_span   = sat_add(r_span, 2'd1);
                    absorbed = 1'b1;
                    if (c == "\"") begin
                        e_kind[e_cnt]  = K_STRING;
                        e_start[e_cnt] = r_begin;
                        e_len[e_cnt]   = n_span;
                        e_cnt  = e_cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == "\n") begin
                        n_line = (r_line == '1) ? r_line : r_line + NW'(1);
                    end
                end
                M_OPER: begin
                    if (c == "=") begin
                        e_kind[e_cnt]  = oper_kind(r_op, 1'b1);
                        e_start[e_cnt] = r_begin;
                        e_len[e_cnt]   = LW'(2);
                        e_cnt    = e_cnt + 2'd1;
                        n_mode   = M_IDLE;
                        absorbed = 1'b1;
                    end else begin
                        flush_now = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == "/") begin
                        n_mode   = M_COMMENT;
                        absorbed = 1'b1;
                    end else begin
                        flush_now = 1'b1;
                    end
                end
                M_COMMENT: begin
                    absorbed = 1'b1;
                    if (c == "\n") begin
                        n_line = (r_line == '1) ? r_line : r_line + NW'(1);
                        n_mode = M_IDLE;
                    end
                end
                default: begin
                    absorbed = 1'b0;
                end
            endcase
        end

        // Flush the pending token when the byte or the end of source closes it.
        if (flush_now) begin
            unique case (r_mode)
                M_IDENT: begin
                    e_kind[e_cnt]  = kw_kind;
                    e_start[e_cnt] = r_begin;
                    e_len[e_cnt]   = r_span;
                    e_cnt = e_cnt + 2'd1;
                end
                M_NUMBER, M_FRACTION: begin
                    e_kind[e_cnt]  = K_NUMBER;
                    e_start[e_cnt] = r_begin;
                    e_len[e_cnt]   = r_span;
                    e_cnt = e_cnt + 2'd1;
                end
                M_NUMDOT: begin
                    e_kind[e_cnt]  = K_NUMBER;
                    e_start[e_cnt] = r_begin;
                    e_len[e_cnt]   = r_span;
                    e_cnt = e_cnt + 2'd1;
                    e_kind[e_cnt]  = K_DOT;
                    e_start[e_cnt] = r_pos - PW'(1);
                    e_len[e_cnt]   = LW'(1);
                    e_cnt = e_cnt + 2'd1;
                end
                M_STRING: begin
                    e_kind[e_cnt]  = K_ERROR;
                    e_err[e_cnt]   = E_UNTERMINATED;
                    e_start[e_cnt] = r_begin;
                    e_len[e_cnt]   = r_span;
                    e_cnt = e_cnt + 2'd1;
                end
                M_OPER: begin
                    e_kind[e_cnt]  = oper_kind(r_op, 1'b0);
                    e_start[e_cnt] = r_begin;
                    e_len[e_cnt]   = LW'(1);
                    e_cnt = e_cnt + 2'd1;
                end
                M_SLASH: begin
                    e_kind[e_cnt]  = K_SLASH;
                    e_start[e_cnt] = r_begin;
                    e_len[e_cnt]   = LW'(1);
                    e_cnt = e_cnt + 2'd1;
                end
                default: begin
                    e_cnt = e_cnt;
                end
            endcase
            n_mode = M_IDLE;
        end

        // End of source gives EOF; otherwise an unabsorbed byte that is not white space starts a new token.
        if (r_mode != M_DONE && eos) begin
            e_kind[e_cnt]  = K_EOF;
            e_start[e_cnt] = r_pos;
            e_cnt  = e_cnt + 2'd1;
            n_mode = M_DONE;
        end else if (r_mode != M_DONE) begin
            if (!absorbed) begin
                n_begin = r_pos;
                n_span  = LW'(1);
                priority if (c == " " || c == "\r" || c == "\t") begin
                    n_mode = M_IDLE;
                end else if (c == "\n") begin
                    n_line = (r_line == '1) ? r_line : r_line + NW'(1);
                end else if (letter_char(c)) begin
                    n_mode = M_IDENT;
                    n_win  = 48'(c);
                end else if (digit_char(c)) begin
                    n_mode = M_NUMBER;
                end else if (c == "\"") begin
                    n_mode = M_STRING;
                end else if (c == "!" || c == "=" || c == "<" || c == ">") begin
                    n_mode = M_OPER;
                    n_op   = c;
                end else if (c == "/") begin
                    n_mode = M_SLASH;
                end else begin
                    e_start[e_cnt] = r_pos;
                    e_len[e_cnt]   = LW'(1);
                    unique case (c)
                        "(":     e_kind[e_cnt] = K_LPAREN;
                        ")":     e_kind[e_cnt] = K_RPAREN;
                        "{":     e_kind[e_cnt] = K_LBRACE;
                        "}":     e_kind[e_cnt] = K_RBRACE;
                        ",":     e_kind[e_cnt] = K_COMMA;
                        ".":     e_kind[e_cnt] = K_DOT;
                        "-":     e_kind[e_cnt] = K_MINUS;
                        "+":     e_kind[e_cnt] = K_PLUS;
                        ";":     e_kind[e_cnt] = K_SEMICOLON;
                        "*":     e_kind[e_cnt] = K_STAR;
                        default: begin
                            e_kind[e_cnt] = K_ERROR;
                            e_err[e_cnt]  = E_UNEXPECTED;
                        end
                    endcase
                    e_cnt = e_cnt + 2'd1;
                end
            end
            n_pos = r_pos + PW'(1);
        end
    end

    // Scanner state, result buffer and its read pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_op    <= '0;
            r_pos   <= '0;
            r_begin <= '0;
            r_span  <= '0;
            r_line  <= NW'(1);
            r_win   <= '0;
            r_cnt   <= 2'd0;
            r_rd    <= 2'd0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_op    <= n_op;
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_span  <= n_span;
            r_line  <= n_line;
            r_win   <= n_win;
            r_cnt   <= e_cnt;
            r_rd    <= 2'd0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_rd <= r_rd + 2'd1;
        end
    end

    // Token payload is written on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                r_data[i] <= DATA_WIDTH'({r_line, e_len[i], e_start[i], e_err[i], e_kind[i]});
                r_last[i] <= (2'(i) == e_cnt - 2'd1);
            end
        end
    end

endmodule

FILE: sv/sts_checker.sv
// Port-level checks for the script token scanner, bound to its top level.
// Depends on script_token_scanner ports only.
module sts_checker #(
    parameter int DATA_WIDTH = 72
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [7:0]            i_s_axis_tdata,
    input logic                  i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [DATA_WIDTH-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tlast
);

    // A stalled output beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata) && o_m_axis_tvalid)
        else $error("output beat changed while stalled");

    // Nothing is offered right after reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Token kinds stay within the defined range.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[5:0] <= 6'd39)
        else $error("token kind out of range");

    // An error code only travels with an error token.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[7:6] != 2'd0 |-> o_m_axis_tdata[5:0] == 6'd38)
        else $error("error code on a non-error token");

    // With tokens queued, the scanner takes a beat only once the buffer is down to its final token and it leaves.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready && o_m_axis_tvalid |-> i_m_axis_tready && o_m_axis_tlast)
        else $error("input taken while results still queued");

endmodule

bind script_token_scanner sts_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sts_checker (.*);
